/* sv/owo_pkg.sv */
// ----------------------------------------------------------------------------
// owo_pkg
// Shared types and constants of the omni wheel odometry unit.
// ----------------------------------------------------------------------------
package owo_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam int MW = 34;
    localparam int PW = 2 * MW;

    localparam logic [63:0]   TWO_PI_Q32     = 64'd26986075409;
    localparam logic [MW-1:0] HALF_PI_Q32    = 34'd6746518852;
    localparam logic [MW-1:0] INV_TWO_PI_Q32 = 34'd683565276;
    localparam logic [30:0]   ONE_Q30        = 31'd1073741824;

    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam logic [2:0] REG_KIN0   = 3'd0;
    localparam logic [2:0] REG_KIN1   = 3'd1;
    localparam logic [2:0] REG_KIN2   = 3'd2;
    localparam logic [2:0] REG_TICKS  = 3'd3;
    localparam logic [2:0] REG_ORIGIN = 3'd4;

    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_SETPOSE,
        MOP_WHL,
        MOP_KIN,
        MOP_HEAD,
        MOP_PHASE,
        MOP_MAG,
        MOP_SQ,
        MOP_DIVS2,
        MOP_DIVTMP,
        MOP_MULT,
        MOP_MULC,
        MOP_UT,
        MOP_QUAD,
        MOP_ROT
    } t_mop;

    typedef struct packed {
        t_mop       mop;
        logic [3:0] idx;
    } t_uop;

    typedef struct packed {
        logic in_load;
        logic out_load;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic [2:0][47:0] kin;
        logic [31:0]      ticks;
        logic [15:0]      origin;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POSE,
        S_RUN,
        S_DONE
    } t_state;

    localparam int PROG_LEN = 38;

endpackage

/* sv/owo_if.sv */
// ----------------------------------------------------------------------------
// owo_if
// Valid/ready channels of the odometry unit: input items and result items.
// ----------------------------------------------------------------------------
interface owo_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic        [15:0] enc_count_a;
    logic        [15:0] enc_count_b;
    logic        [15:0] enc_count_c;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;

    modport source (output valid, op, enc_count_a, enc_count_b, enc_count_c,
                    new_x, new_y, new_heading, input ready);
    modport sink   (input valid, op, enc_count_a, enc_count_b, enc_count_c,
                    new_x, new_y, new_heading, output ready);
endinterface

interface owo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] local_vx;
    logic signed [31:0] local_vy;
    logic signed [31:0] local_turn;
    logic signed [31:0] wheel_rate_a;
    logic signed [31:0] wheel_rate_b;
    logic signed [31:0] wheel_rate_c;

    modport source (output valid, pose_x, pose_y, pose_heading, local_vx, local_vy,
                    local_turn, wheel_rate_a, wheel_rate_b, wheel_rate_c, input ready);
    modport sink   (input valid, pose_x, pose_y, pose_heading, local_vx, local_vy,
                    local_turn, wheel_rate_a, wheel_rate_b, wheel_rate_c, output ready);
endinterface

/* sv/owo_cfg.sv */
// ----------------------------------------------------------------------------
// owo_cfg
// APB register file: kinematics rows, tick scale and count origin.
// ----------------------------------------------------------------------------
module owo_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owo_pkg::PADDR_W-1:0]  paddr,
    input  logic [owo_pkg::PDATA_W-1:0]  pwdata,
    output logic [owo_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output owo_pkg::t_cfg                o_cfg
);
    import owo_pkg::*;

    logic [2:0][47:0] r_kin;
    logic [31:0]      r_ticks;
    logic [15:0]      r_origin;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kin    <= '0;
            r_ticks  <= '0;
            r_origin <= 16'd32768;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KIN0:   r_kin[0] <= pwdata[47:0];
                REG_KIN1:   r_kin[1] <= pwdata[47:0];
                REG_KIN2:   r_kin[2] <= pwdata[47:0];
                REG_TICKS:  r_ticks  <= pwdata[31:0];
                REG_ORIGIN: r_origin <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KIN0:   prdata = {16'd0, r_kin[0]};
            REG_KIN1:   prdata = {16'd0, r_kin[1]};
            REG_KIN2:   prdata = {16'd0, r_kin[2]};
            REG_TICKS:  prdata = {32'd0, r_ticks};
            REG_ORIGIN: prdata = {48'd0, r_origin};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{kin: r_kin, ticks: r_ticks, origin: r_origin};

endmodule

/* sv/owo_ctrl.sv */
// ----------------------------------------------------------------------------
// owo_ctrl
// Sequencer: steps the datapath through the micro-op program of one item.
// ----------------------------------------------------------------------------
module owo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output owo_pkg::t_cmd o_cmd
);
    import owo_pkg::*;

    localparam int CW = $clog2(2 * PROG_LEN);
    localparam logic [CW-1:0] CNT_LAST = CW'(2 * PROG_LEN - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_ovalid;
    logic          in_xfer;
    logic          out_free;

    function automatic t_uop prog(input logic [CW-2:0] s);
        t_uop u;
        u.idx = 4'd0;
        case (s)
            0, 1, 2:  begin u.mop = MOP_WHL;   u.idx = 4'(s); end
            3, 4, 5:  begin u.mop = MOP_KIN;   u.idx = {2'd0, 2'(s - 3)}; end
            6, 7, 8:  begin u.mop = MOP_KIN;   u.idx = {2'd1, 2'(s - 6)}; end
            9, 10, 11: begin u.mop = MOP_KIN;  u.idx = {2'd2, 2'(s - 9)}; end
            12:       u.mop = MOP_HEAD;
            13:       u.mop = MOP_PHASE;
            14:       u.mop = MOP_MAG;
            15:       u.mop = MOP_SQ;
            16:       begin u.mop = MOP_DIVS2;  u.idx = 4'd0; end
            17, 19, 21: u.mop = MOP_MULT;
            18:       begin u.mop = MOP_DIVTMP; u.idx = 4'd1; end
            20:       begin u.mop = MOP_DIVTMP; u.idx = 4'd2; end
            22:       begin u.mop = MOP_DIVTMP; u.idx = 4'd3; end
            23:       u.mop = MOP_UT;
            24:       begin u.mop = MOP_DIVS2;  u.idx = 4'd4; end
            25, 27, 29, 31: u.mop = MOP_MULC;
            26:       begin u.mop = MOP_DIVTMP; u.idx = 4'd5; end
            28:       begin u.mop = MOP_DIVTMP; u.idx = 4'd6; end
            30:       begin u.mop = MOP_DIVTMP; u.idx = 4'd7; end
            32:       begin u.mop = MOP_DIVTMP; u.idx = 4'd8; end
            33:       u.mop = MOP_QUAD;
            34, 35, 36, 37: begin u.mop = MOP_ROT; u.idx = 4'(s - 34); end
            default:  u.mop = MOP_NONE;
        endcase
        return u;
    endfunction

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = i_in_op ? S_POSE : S_RUN;
            S_POSE: if (r_cnt[0]) n_state = S_DONE;
            S_RUN:  if (r_cnt == CNT_LAST) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd        = '0;
        o_cmd.uop.mop = MOP_NONE;
        case (r_state)
            S_IDLE: o_cmd.in_load = in_xfer;
            S_POSE: if (!r_cnt[0]) o_cmd.uop.mop = MOP_SETPOSE;
            S_RUN:  if (!r_cnt[0]) o_cmd.uop = prog(r_cnt[CW-1:1]);
            S_DONE: o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (r_state == S_RUN || r_state == S_POSE) ? r_cnt + 1'b1 : '0;
            if (o_cmd.out_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

endmodule

/* sv/owo_dp.sv */
// ----------------------------------------------------------------------------
// owo_dp
// Datapath: one shared 34x34 multiplier, pose state and output register.
// ----------------------------------------------------------------------------
module owo_dp #(
    parameter int FRAC_BITS = owo_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  owo_pkg::t_cmd      i_cmd,
    input  owo_pkg::t_cfg      i_cfg,
    input  logic        [15:0] i_enc_a,
    input  logic        [15:0] i_enc_b,
    input  logic        [15:0] i_enc_c,
    input  logic signed [31:0] i_new_x,
    input  logic signed [31:0] i_new_y,
    input  logic signed [31:0] i_new_h,
    output logic signed [31:0] o_res [9]
);
    import owo_pkg::*;

    localparam logic signed [33:0] TWO_PI_F =
        34'((TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

    logic        [15:0] r_enc [3];
    logic signed [31:0] r_nx, r_ny, r_nh;
    logic signed [31:0] r_wr [3];
    logic signed [31:0] r_ls [3];
    logic signed [31:0] r_x, r_y, r_h;
    logic signed [PW-1:0] r_prod, r_acc;
    t_mop               r_pmop;
    logic [3:0]         r_pidx;
    logic [1:0]         r_q;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [30:0]        r_u, r_s2, r_t, r_c, r_tmp, r_sn0;
    logic signed [31:0] r_sn, r_cs;
    logic signed [31:0] r_out [9];

    logic signed [MW-1:0] opa, opb;
    logic        [15:0]   diff, coef;
    logic        [1:0]    wi, row;
    logic signed [PW-1:0] kin_sum, rot_sum;
    logic signed [33:0]   hsum;
    logic        [31:0]   ph, qsum, rr;
    logic        [30:0]   quo;
    logic signed [31:0]   s0, c0;

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        if (v > PW'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -PW'(64'sh8000_0000)) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                input int s);
        logic signed [PW-1:0] one;
        one = PW'(1);
        return (v + (one <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [MW-1:0] div_mul(input logic [3:0] i);
        case (i)
            4'd0:    return MW'((64'd1 << 37) / 72 + 1);
            4'd1:    return MW'((64'd1 << 36) / 42 + 1);
            4'd2:    return MW'((64'd1 << 35) / 20 + 1);
            4'd3:    return MW'((64'd1 << 33) / 6 + 1);
            4'd4:    return MW'((64'd1 << 37) / 90 + 1);
            4'd5:    return MW'((64'd1 << 36) / 56 + 1);
            4'd6:    return MW'((64'd1 << 35) / 30 + 1);
            4'd7:    return MW'((64'd1 << 34) / 12 + 1);
            default: return MW'((64'd1 << 31) / 2 + 1);
        endcase
    endfunction

    function automatic logic [5:0] div_sh(input logic [3:0] i);
        case (i)
            4'd0, 4'd4: return 6'd37;
            4'd1, 4'd5: return 6'd36;
            4'd2, 4'd6: return 6'd35;
            4'd3:       return 6'd33;
            4'd7:       return 6'd34;
            default:    return 6'd31;
        endcase
    endfunction

    assign wi   = i_cmd.uop.idx[1:0];
    assign row  = i_cmd.uop.idx[3:2];
    assign diff = r_enc[wi] - i_cfg.origin;
    assign coef = i_cfg.kin[row][16*wi +: 16];

    always_comb begin
        opa = '0;
        opb = '0;
        case (i_cmd.uop.mop)
            MOP_WHL: begin
                opa = {{18{diff[15]}}, diff};
                opb = {2'b00, i_cfg.ticks};
            end
            MOP_KIN: begin
                opa = {{18{coef[15]}}, coef};
                opb = {{2{r_wr[wi][31]}}, r_wr[wi]};
            end
            MOP_PHASE: begin
                opa = {{2{r_h[31]}}, r_h};
                opb = INV_TWO_PI_Q32;
            end
            MOP_MAG:    begin opa = {2'b00, r_mag}; opb = HALF_PI_Q32; end
            MOP_SQ:     begin opa = {3'b0, r_u};   opb = {3'b0, r_u}; end
            MOP_DIVS2:  begin opa = {3'b0, r_s2};  opb = div_mul(i_cmd.uop.idx); end
            MOP_DIVTMP: begin opa = {3'b0, r_tmp}; opb = div_mul(i_cmd.uop.idx); end
            MOP_MULT:   begin opa = {3'b0, r_s2};  opb = {3'b0, r_t}; end
            MOP_MULC:   begin opa = {3'b0, r_s2};  opb = {3'b0, r_c}; end
            MOP_UT:     begin opa = {3'b0, r_u};   opb = {3'b0, r_t}; end
            MOP_ROT: begin
                opa = (wi[0]) ? {{2{r_ls[1][31]}}, r_ls[1]} : {{2{r_ls[0][31]}}, r_ls[0]};
                opb = (wi == 2'd0 || wi == 2'd3) ? {{2{r_cs[31]}}, r_cs}
                                                 : {{2{r_sn[31]}}, r_sn};
            end
            default: ;
        endcase
    end

    // write-back side, in the cycle after issue
    always_comb begin
        kin_sum = ((r_pidx[1:0] == 2'd0) ? '0 : r_acc) + r_prod;
        rot_sum = (r_pidx[1:0] == 2'd1) ? r_acc - r_prod : r_acc + r_prod;
        hsum    = 34'(r_h) + 34'(r_ls[2]);
        if (hsum > TWO_PI_F) hsum = hsum - TWO_PI_F;
        else if (hsum < -TWO_PI_F) hsum = hsum + TWO_PI_F;
        ph   = r_prod[FRAC_BITS +: 32];
        qsum = ph + 32'h2000_0000;
        rr   = ph - {qsum[31:30], 30'd0};
        quo  = 31'(($unsigned(r_prod)) >> div_sh(r_pidx));
        s0   = r_neg ? -$signed({1'b0, r_sn0}) : $signed({1'b0, r_sn0});
        c0   = $signed({1'b0, r_c});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_enc[0] <= i_enc_a;
            r_enc[1] <= i_enc_b;
            r_enc[2] <= i_enc_c;
            r_nx     <= i_new_x;
            r_ny     <= i_new_y;
            r_nh     <= i_new_h;
        end
        r_prod <= opa * opb;
        r_pidx <= i_cmd.uop.idx;
        case (r_pmop)
            MOP_KIN: r_acc <= kin_sum;
            MOP_PHASE: begin
                r_q   <= qsum[31:30];
                r_neg <= rr[31];
                r_mag <= rr[31] ? 32'd0 - rr : rr;
            end
            MOP_MAG:  r_u  <= 31'((r_prod + PW'(64'h8000_0000)) >>> 32);
            MOP_SQ:   r_s2 <= 31'(r_prod >>> 30);
            MOP_DIVS2, MOP_DIVTMP: begin
                if (r_pidx < 4'd4) r_t <= ONE_Q30 - quo;
                else               r_c <= ONE_Q30 - quo;
            end
            MOP_MULT, MOP_MULC: r_tmp <= 31'(r_prod >>> 30);
            MOP_UT:   r_sn0 <= 31'(r_prod >>> 30);
            MOP_QUAD: begin
                case (r_q)
                    2'd0:    begin r_sn <= s0;  r_cs <= c0;  end
                    2'd1:    begin r_sn <= c0;  r_cs <= -s0; end
                    2'd2:    begin r_sn <= -s0; r_cs <= -c0; end
                    default: begin r_sn <= -c0; r_cs <= s0;  end
                endcase
            end
            MOP_ROT: if (!r_pidx[0]) r_acc <= r_prod;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out[0] <= r_x;
            r_out[1] <= r_y;
            r_out[2] <= r_h;
            r_out[3] <= r_ls[0];
            r_out[4] <= r_ls[1];
            r_out[5] <= r_ls[2];
            r_out[6] <= r_wr[0];
            r_out[7] <= r_wr[1];
            r_out[8] <= r_wr[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmop <= MOP_NONE;
            r_x    <= '0;
            r_y    <= '0;
            r_h    <= '0;
            r_wr   <= '{default: '0};
            r_ls   <= '{default: '0};
        end else begin
            r_pmop <= i_cmd.uop.mop;
            case (r_pmop)
                MOP_SETPOSE: begin
                    r_x <= r_nx;
                    r_y <= r_ny;
                    r_h <= r_nh;
                end
                MOP_WHL: r_wr[r_pidx[1:0]] <= sat32(rnd(r_prod, 32 - FRAC_BITS));
                MOP_KIN: if (r_pidx[1:0] == 2'd2) r_ls[r_pidx[3:2]] <= sat32(rnd(kin_sum, 12));
                MOP_HEAD: r_h <= sat32(PW'(hsum));
                MOP_ROT: begin
                    if (r_pidx[1:0] == 2'd1) r_x <= sat32(PW'(r_x) + rnd(rot_sum, 30));
                    if (r_pidx[1:0] == 2'd3) r_y <= sat32(PW'(r_y) + rnd(rot_sum, 30));
                end
                default: ;
            endcase
        end
    end

    assign o_res = r_out;

endmodule

/* sv/omni_wheel_odometry_unit.sv */
// ----------------------------------------------------------------------------
// omni_wheel_odometry_unit
// Three-wheel omni odometry: wheel increments, kinematics, heading, pose.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready channel. op=0 is a tick with three encoder counts,
//           op=1 loads x, y and heading. Every item yields one result.
//   o_out : valid/ready channel with pose, local increments, wheel rates.
//   APB   : 64-bit registers at 8*i: kin_row0..2, ticks_scale, count_origin.
//           Write only while the block is idle.
// Operation: a tick runs 38 micro-ops in turn on one shared 34x34
//   multiplier, between the accept and result-load steps; the sine and
//   cosine series (17 ops) dominate. A set-pose item runs a single
//   micro-op. One item is in work at a time.
// The result sits in an output register; the next item is accepted while
//   it waits, but its own result is held back until the receiver takes
//   the previous one. Reset clears the pose, the increments and the
//   registers (count_origin goes to 32768); no result is pending.
// ----------------------------------------------------------------------------
module omni_wheel_odometry_unit #(
    parameter int FRAC_BITS = owo_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owo_pkg::PADDR_W-1:0] paddr,
    input  logic [owo_pkg::PDATA_W-1:0] pwdata,
    output logic [owo_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    owo_in_if.sink                      i_in,
    owo_out_if.source                   o_out
);
    import owo_pkg::*;

    t_cfg               cfg;
    t_cmd               cmd;
    logic signed [31:0] res [9];

    owo_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    owo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    owo_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_enc_a (i_in.enc_count_a),
        .i_enc_b (i_in.enc_count_b),
        .i_enc_c (i_in.enc_count_c),
        .i_new_x (i_in.new_x),
        .i_new_y (i_in.new_y),
        .i_new_h (i_in.new_heading),
        .o_res   (res)
    );

    assign o_out.pose_x       = res[0];
    assign o_out.pose_y       = res[1];
    assign o_out.pose_heading = res[2];
    assign o_out.local_vx     = res[3];
    assign o_out.local_vy     = res[4];
    assign o_out.local_turn   = res[5];
    assign o_out.wheel_rate_a = res[6];
    assign o_out.wheel_rate_b = res[7];
    assign o_out.wheel_rate_c = res[8];

endmodule

/* sv/owo_chk.sv */
// ----------------------------------------------------------------------------
// owo_chk
// Port-level checks of the odometry unit, bound to the top level.
// ----------------------------------------------------------------------------
module owo_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x
);
    logic [1:0] r_pend;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= '0;
        else r_pend <= r_pend + {1'b0, in_xfer} - {1'b0, out_xfer};
    end

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> r_pend != 2'd0) else $error("result without item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> r_pend <= 2'd1) else $error("too many items in flight");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !out_valid) else $error("valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x))
        else $error("result dropped while stalled");

endmodule

bind omni_wheel_odometry_unit owo_chk u_owo_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_x     (o_out.pose_x)
);
